>>> hw/rtl/flock_separation_steer_assert.svh
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef FLOCK_SEPARATION_STEER_ASSERT_SVH
`define FLOCK_SEPARATION_STEER_ASSERT_SVH

// same-cycle implication under active-low reset
`define FSS_ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication under active-low reset
`define FSS_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/fss_pkg.sv
// shared types and constants of the separation steering block
// no dependencies
package fss_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned DIFF_W  = POS_W + 1;
  localparam int unsigned D2_W    = 50;
  localparam int unsigned QUOT_W  = 37;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned STEER_W = 32;
  localparam int unsigned CFG_W   = D2_W;
  localparam int unsigned CNT_W   = 6;

  localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd256;
  localparam logic [D2_W-1:0]   RADIUS_RESET = 50'd16777216;

  // register indexes of the configuration port
  localparam logic CFG_GAIN   = 1'b0;
  localparam logic CFG_RADIUS = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SQ   = 8'b0000_0010,
    ST_CHK  = 8'b0000_0100,
    ST_DIV  = 8'b0000_1000,
    ST_ACC  = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_SAT  = 8'b0100_0000,
    ST_PUSH = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] self_x;
    logic signed [POS_W-1:0] self_y;
    logic signed [POS_W-1:0] self_z;
    logic signed [POS_W-1:0] other_x;
    logic signed [POS_W-1:0] other_y;
    logic signed [POS_W-1:0] other_z;
    logic                    is_self;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [STEER_W-1:0] steer_x;
    logic signed [STEER_W-1:0] steer_y;
    logic signed [STEER_W-1:0] steer_z;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       sq_step;
    logic       div_init;
    logic       div_step;
    logic       acc_upd;
    logic       mul;
    logic       sat;
    logic       push;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic counted;
    logic last;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/fss_if.sv
// valid/ready channel interfaces for input beats and result beats
// depends on fss_pkg
interface fss_in_if import fss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] self_x;
  logic signed [POS_W-1:0] self_y;
  logic signed [POS_W-1:0] self_z;
  logic signed [POS_W-1:0] other_x;
  logic signed [POS_W-1:0] other_y;
  logic signed [POS_W-1:0] other_z;
  logic                    is_self;
  logic                    last;

  modport source (output valid, self_x, self_y, self_z, other_x, other_y, other_z,
                  is_self, last, input ready);
  modport sink   (input valid, self_x, self_y, self_z, other_x, other_y, other_z,
                  is_self, last, output ready);
endinterface

interface fss_out_if import fss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [STEER_W-1:0] steer_x;
  logic signed [STEER_W-1:0] steer_y;
  logic signed [STEER_W-1:0] steer_z;

  modport source (output valid, steer_x, steer_y, steer_z, input ready);
  modport sink   (input valid, steer_x, steer_y, steer_z, output ready);
endinterface

>>> hw/rtl/fss_ctrl.sv
// sequencer of the separation steering block
// depends on fss_pkg; drives datapath commands, reads datapath status
module fss_ctrl import fss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= AXIS_X;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          axis_nxt  = AXIS_X;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = ST_CHK;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      ST_CHK: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        axis_nxt     = AXIS_X;
        if (sts.counted) begin
          state_nxt = ST_DIV;
        end else if (sts.last) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_upd = 1'b1;
        axis_nxt    = AXIS_X;
        state_nxt   = sts.last ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        cmd.sat = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = ST_PUSH;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/fss_datapath.sv
// datapath: squared distance, radial divide, accumulate, gain and saturate
// depends on fss_pkg; commanded by fss_ctrl
module fss_datapath import fss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output out_item_t        out_item,
  output logic             out_valid,
  input  logic             out_ready
);

  logic signed [GAIN_W-1:0]  gain_r;
  logic [D2_W-1:0]           rad_r;
  logic signed [DIFF_W-1:0]  d_r [3];
  logic                      is_self_r;
  logic                      last_r;
  logic [D2_W-1:0]           d2_r;
  logic [D2_W-1:0]           rem_r [3];
  logic [QUOT_W-1:0]         sh_r [3];
  logic signed [ACC_W-1:0]   acc_r [3];
  logic signed [63:0]        prod_r;
  logic signed [STEER_W-1:0] res_r [3];
  out_item_t                 out_r;
  logic                      out_valid_r;

  logic signed [DIFF_W-1:0]  sq_in;
  logic signed [D2_W-1:0]    sq;
  logic signed [ACC_W-1:0]   mul_a;
  logic signed [63:0]        prod;
  logic signed [63:0]        adj;
  logic signed [63:0]        shr;
  logic signed [STEER_W-1:0] sat_val;

  function automatic logic [POS_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] t;
    t = v[DIFF_W-1] ? -v : v;
    return t[POS_W-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      rad_r  <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN:   gain_r <= cfg_data[GAIN_W-1:0];
        CFG_RADIUS: rad_r  <= cfg_data[D2_W-1:0];
        default:    gain_r <= gain_r;
      endcase
    end
  end

  // squared distance, one axis a cycle through one squarer
  always_comb begin
    case (cmd.axis)
      AXIS_X:  sq_in = d_r[0];
      AXIS_Y:  sq_in = d_r[1];
      default: sq_in = d_r[2];
    endcase
  end
  assign sq = sq_in * sq_in;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r[0]    <= DIFF_W'(in_item.self_x) - DIFF_W'(in_item.other_x);
      d_r[1]    <= DIFF_W'(in_item.self_y) - DIFF_W'(in_item.other_y);
      d_r[2]    <= DIFF_W'(in_item.self_z) - DIFF_W'(in_item.other_z);
      is_self_r <= in_item.is_self;
      last_r    <= in_item.last;
      d2_r      <= '0;
    end else if (cmd.sq_step) begin
      d2_r <= d2_r + D2_W'(sq);
    end
  end

  assign sts.counted  = !is_self_r && (d2_r < rad_r) && (d2_r != '0);
  assign sts.last     = last_r;
  assign sts.out_free = !out_valid_r || out_ready;

  // per-axis restoring divider and saturating accumulator
  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [POS_W-1:0]        mag;
    logic [D2_W:0]           rem2;
    logic [D2_W:0]           diff;
    logic                    ge;
    logic signed [QUOT_W+1:0] qs;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] acc_nxt;

    always_comb begin
      mag  = abs_diff(d_r[i]);
      rem2 = {rem_r[i], sh_r[i][QUOT_W-1]};
      diff = rem2 - {1'b0, d2_r};
      ge   = (rem2 >= {1'b0, d2_r});
      qs   = d_r[i][DIFF_W-1] ? -$signed({2'b00, sh_r[i]}) : $signed({2'b00, sh_r[i]});
      sum  = (ACC_W+1)'(acc_r[i]) + (ACC_W+1)'(qs);
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_nxt = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_nxt = sum[ACC_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.div_init) begin
        rem_r[i] <= D2_W'(mag >> 1);
        sh_r[i]  <= {mag[0], {(QUOT_W-1){1'b0}}};
      end else if (cmd.div_step) begin
        rem_r[i] <= ge ? diff[D2_W-1:0] : rem2[D2_W-1:0];
        sh_r[i]  <= {sh_r[i][QUOT_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r[i] <= '0;
      end else if (cmd.push) begin
        acc_r[i] <= '0;
      end else if (cmd.acc_upd) begin
        acc_r[i] <= acc_nxt;
      end
    end
  end

  // gain multiply, one axis per pass
  always_comb begin
    case (cmd.axis)
      AXIS_X:  mul_a = acc_r[0];
      AXIS_Y:  mul_a = acc_r[1];
      default: mul_a = acc_r[2];
    endcase
  end
  assign prod = mul_a * gain_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod;
    end
  end

  // truncate toward zero by 2^16 and saturate to 32 bits
  always_comb begin
    adj = prod_r + (prod_r[63] ? 64'sd65535 : 64'sd0);
    shr = adj >>> 16;
    if (shr[63:STEER_W-1] != {(64-STEER_W+1){shr[63]}}) begin
      sat_val = shr[63] ? {1'b1, {(STEER_W-1){1'b0}}} : {1'b0, {(STEER_W-1){1'b1}}};
    end else begin
      sat_val = shr[STEER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      case (cmd.axis)
        AXIS_X:  res_r[0] <= sat_val;
        AXIS_Y:  res_r[1] <= sat_val;
        default: res_r[2] <= sat_val;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_r.steer_x <= res_r[0];
      out_r.steer_y <= res_r[1];
      out_r.steer_z <= res_r[2];
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/flock_separation_steer.sv
// top level of the boids separation steering block
// depends on fss_pkg, fss_if, fss_ctrl, fss_datapath
//
// channel   dir  handshake      beat
// in_ch     in   valid/ready    own and neighbor position, is_self, last
// out_ch    out  valid/ready    steer_x/y/z, Q16.16 saturated
// cfg_*     in   cfg_we only    gain (index 0), radius_squared (index 1)
//
// a counted neighbor goes through accept, one squarer step per axis, a check,
// one divider step per quotient bit and an accumulate; a skipped one leaves out
// the divide and accumulate. a last beat then adds gain multiply and saturation
// per axis and a load of the output register. the divider's one quotient bit
// per cycle sets the rate. reset is synchronous; the next beat waits while a
// result is ready but the previous one has not left the output register.
module flock_separation_steer import fss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  fss_in_if.sink           in_ch,
  fss_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t      cmd;
  sts_t      sts;
  in_item_t  in_item;
  out_item_t out_item;

  // payload gathering
  assign in_item.self_x  = in_ch.self_x;
  assign in_item.self_y  = in_ch.self_y;
  assign in_item.self_z  = in_ch.self_z;
  assign in_item.other_x = in_ch.other_x;
  assign in_item.other_y = in_ch.other_y;
  assign in_item.other_z = in_ch.other_z;
  assign in_item.is_self = in_ch.is_self;
  assign in_item.last    = in_ch.last;

  fss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fss_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  assign out_ch.steer_x = out_item.steer_x;
  assign out_ch.steer_y = out_item.steer_y;
  assign out_ch.steer_z = out_item.steer_z;

endmodule

>>> hw/rtl/fss_checker.sv
// port-level checks of the separation steering block, bound to the top level
// depends on fss_pkg and flock_separation_steer_assert.svh
`include "flock_separation_steer_assert.svh"

module fss_checker import fss_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [STEER_W-1:0] steer_x
);

  // a result beat holds until taken
  `FSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result keeps its steer_x payload
  `FSS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(steer_x))

  // one beat at a time: the block is busy right after an accept
  `FSS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // a fresh result comes with the sequencer back at idle
  `FSS_ASSERT_IMPLY(a_idle_on_result, clk, rst_n, $rose(out_valid), in_ready)

endmodule

bind flock_separation_steer fss_checker u_fss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .steer_x   (out_ch.steer_x)
);

>>> tb/sv/tb.sv
// self-checking testbench for the separation steering block
// depends on fss_pkg, fss_if and flock_separation_steer from the rtl
`timescale 1ns / 100ps

module tb;
  import fss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam longint     ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint     ACC_LO = -ACC_HI - 1;
  localparam longint     STEER_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint     STEER_LO = -STEER_HI - 1;
  localparam int         POS_HI = 8388607;
  localparam int         POS_LO = -8388608;

  // tracks the accumulator and registers, and holds the expected steer beats
  class steer_scoreboard;
    longint gain_q88;
    longint radius_sq;
    longint acc_x, acc_y, acc_z;
    out_item_t steer_q[$];
    int unsigned mismatches;
    int unsigned steers_seen;

    function new();
      gain_q88 = 256;
      radius_sq = 64'd16777216;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      mismatches = 0;
      steers_seen = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_GAIN) gain_q88 = longint'($signed(val[GAIN_W-1:0]));
      else radius_sq = longint'({14'd0, val});
    endfunction

    // one counted neighbor: add d / d2 in q24.24, saturate to 48 bits
    function longint add_repel(longint acc, longint d, longint d2);
      longint q, s;
      q = (d * 64'sd68719476736) / d2;
      s = acc + q;
      if (s > ACC_HI) s = ACC_HI;
      if (s < ACC_LO) s = ACC_LO;
      return s;
    endfunction

    function logic signed [STEER_W-1:0] scale_steer(longint acc);
      longint p;
      p = (acc * gain_q88) / 65536;
      if (p > STEER_HI) p = STEER_HI;
      if (p < STEER_LO) p = STEER_LO;
      return p[STEER_W-1:0];
    endfunction

    function void note_beat(in_item_t b);
      longint dx, dy, dz, d2;
      out_item_t s;
      dx = longint'($signed(b.self_x)) - longint'($signed(b.other_x));
      dy = longint'($signed(b.self_y)) - longint'($signed(b.other_y));
      dz = longint'($signed(b.self_z)) - longint'($signed(b.other_z));
      d2 = dx * dx + dy * dy + dz * dz;
      if (!b.is_self && d2 != 0 && d2 < radius_sq) begin
        acc_x = add_repel(acc_x, dx, d2);
        acc_y = add_repel(acc_y, dy, d2);
        acc_z = add_repel(acc_z, dz, d2);
      end
      if (b.last) begin
        s.steer_x = scale_steer(acc_x);
        s.steer_y = scale_steer(acc_y);
        s.steer_z = scale_steer(acc_z);
        steer_q = {steer_q, s};
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t exp;
      steers_seen++;
      if (steer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected steer beat x=%0d y=%0d z=%0d",
                   got.steer_x, got.steer_y, got.steer_z);
        return;
      end
      exp = steer_q.pop_front();
      if (got != exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("steer mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                   exp.steer_x, exp.steer_y, exp.steer_z,
                   got.steer_x, got.steer_y, got.steer_z);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  fss_in_if  in_ch();
  fss_out_if out_ch();

  flock_separation_steer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  steer_scoreboard sb;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int unsigned cycles = 0;
  int unsigned beats_sent = 0;
  int unsigned queries = 0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("flock_separation_steer regression: fail");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_beat('{out_ch.steer_x, out_ch.steer_y, out_ch.steer_z});
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one beat and wait for its handshake; valid stays high afterwards
  task automatic send_beat(in_item_t b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.self_x  <= b.self_x;
    in_ch.self_y  <= b.self_y;
    in_ch.self_z  <= b.self_z;
    in_ch.other_x <= b.other_x;
    in_ch.other_y <= b.other_y;
    in_ch.other_z <= b.other_z;
    in_ch.is_self <= b.is_self;
    in_ch.last    <= b.last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(b);
    beats_sent++;
    if (b.last) queries++;
  endtask

  // idle the input and wait until every expected steer beat has left
  task automatic drain();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (sb.steer_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one register write, on its own edge so enables never collide
  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom());
  endfunction

  // position near s, clamped to the q12.12 range
  function automatic logic [POS_W-1:0] near(logic signed [POS_W-1:0] s, int span);
    int v;
    v = int'(s) + $urandom_range(0, 2 * span) - span;
    if (v > POS_HI) v = POS_HI;
    if (v < POS_LO) v = POS_LO;
    return v[POS_W-1:0];
  endfunction

  function automatic in_item_t mk(logic [POS_W-1:0] sx, sy, sz, ox, oy, oz,
                                  logic slf, logic lst);
    in_item_t b;
    b.self_x = sx; b.self_y = sy; b.self_z = sz;
    b.other_x = ox; b.other_y = oy; b.other_z = oz;
    b.is_self = slf;
    b.last = lst;
    return b;
  endfunction

  // one agent's query with random neighbors, mostly inside the radius
  task automatic rand_query(int n, int span);
    in_item_t b;
    logic [POS_W-1:0] sx, sy, sz;
    int kind;
    sx = rand_pos();
    sy = rand_pos();
    sz = rand_pos();
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 15);
      b = mk(sx, sy, sz, near(sx, span), near(sy, span), near(sz, span),
             1'b0, i == n - 1);
      if (kind == 0) begin
        b.other_x = sx; b.other_y = sy; b.other_z = sz; b.is_self = 1'b1;
      end else if (kind == 1) begin
        b.other_x = sx; b.other_y = sy; b.other_z = sz;
      end else if (kind == 2) begin
        b.other_x = rand_pos(); b.other_y = rand_pos(); b.other_z = rand_pos();
      end else if (kind == 3) begin
        b.is_self = 1'b1;
      end
      send_beat(b);
    end
  endtask

  task automatic rand_phase(int nq);
    for (int q = 0; q < nq; q++)
      rand_query($urandom_range(1, 6), 1 << $urandom_range(0, 13));
  endtask

  initial begin
    logic [POS_W-1:0] pmax, pmin, zero;
    pmax = POS_W'(POS_HI);
    pmin = POS_W'(POS_LO);
    zero = '0;
    sb = new();
    cfg_we = 1'b0;
    cfg_index = CFG_GAIN;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.self_x = '0; in_ch.self_y = '0; in_ch.self_z = '0;
    in_ch.other_x = '0; in_ch.other_y = '0; in_ch.other_z = '0;
    in_ch.is_self = 1'b0;
    in_ch.last = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, empty query, coincident, skipped last
    send_beat(mk(zero, zero, zero, zero, zero, zero, 1'b1, 1'b1));
    send_beat(mk(pmax, pmax, pmax, pmin, pmin, pmin, 1'b0, 1'b1));
    send_beat(mk(zero, zero, zero, zero, zero, zero, 1'b0, 1'b1));
    send_beat(mk(24'd1, zero, zero, zero, zero, zero, 1'b0, 1'b0));
    send_beat(mk(zero, 24'd100, zero, zero, zero, zero, 1'b0, 1'b0));
    send_beat(mk(pmax, zero, zero, pmin, zero, zero, 1'b0, 1'b1));
    send_beat(mk(zero, zero, 24'd300, zero, zero, 24'd600, 1'b1, 1'b0));
    send_beat(mk(zero, zero, 24'd300, zero, zero, 24'd600, 1'b0, 1'b1));
    drain();

    // directed: widest radius, extreme gains and positions
    write_reg(CFG_RADIUS, {CFG_W{1'b1}});
    write_reg(CFG_GAIN, 50'h8000);
    send_beat(mk(pmax, pmax, pmax, pmin, pmin, pmin, 1'b0, 1'b0));
    send_beat(mk(pmin, pmin, pmin, pmax, pmax, pmax, 1'b0, 1'b1));
    send_beat(mk(zero, zero, zero, 24'd1, 24'hFFFFFF, zero, 1'b0, 1'b1));
    send_beat(mk(pmin, zero, pmax, pmin, 24'd1, pmax, 1'b0, 1'b1));
    drain();
    write_reg(CFG_GAIN, 50'h7FFF);
    send_beat(mk(24'd5, zero, zero, 24'd4, zero, zero, 1'b0, 1'b1));
    send_beat(mk(zero, zero, zero, zero, zero, 24'hFFFFFF, 1'b0, 1'b1));
    send_beat(mk(pmax, pmin, zero, pmin, pmax, zero, 1'b0, 1'b1));
    drain();

    // random: several register settings
    write_reg(CFG_GAIN, 50'd256);
    write_reg(CFG_RADIUS, 50'd16777216);
    rand_phase(40);
    drain();
    write_reg(CFG_GAIN, 50'h0000);
    write_reg(CFG_RADIUS, 50'd0);
    rand_phase(15);
    drain();
    write_reg(CFG_GAIN, 50'h8000);
    write_reg(CFG_RADIUS, {CFG_W{1'b1}});
    rand_phase(40);

    // long receiver hold-off while beats keep coming
    hold_req = 1'b1;
    rand_phase(20);
    drain();
    write_reg(CFG_GAIN, 50'(16'($urandom())));
    write_reg(CFG_RADIUS, 50'd1 << 30);
    rand_phase(40);

    // sender pauses until everything has come back
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (sb.steer_q.size() != 0) @(posedge clk);
    rand_phase(30);
    drain();

    // large accumulator: many unit-distance neighbors on one axis
    write_reg(CFG_GAIN, 50'd1);
    write_reg(CFG_RADIUS, 50'd16777216);
    for (int i = 0; i < 1100; i++)
      send_beat(mk(24'd1, 24'd7, zero, zero, 24'd7, zero, 1'b0, i == 1099));
    drain();
    write_reg(CFG_GAIN, 50'h7FFF);
    write_reg(CFG_RADIUS, 50'd1 << 28);
    rand_phase(20);

    // last part with no idling
    idle_on = 1'b0;
    rand_phase(20);
    drain();

    $display("%0d input beats in %0d queries, %0d steer beats checked, %0d cycles",
             beats_sent, queries, sb.steers_seen, cycles);
    $display("covered register extremes, coincident and self candidates, saturation");
    if (sb.mismatches == 0 && sb.steer_q.size() == 0) begin
      $display("flock_separation_steer regression: pass");
    end else begin
      $display("%0d mismatches, %0d steer beats missing", sb.mismatches,
               sb.steer_q.size());
      $display("flock_separation_steer regression: fail");
    end
    $finish;
  end

endmodule
